>>> rtl/core/nmea_rmc_time_date_parser_assert.svh
// ----------------------------------------------------------------------------
// NMEA RMC parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_TIME_DATE_PARSER_ASSERT_SVH
`define NMEA_RMC_TIME_DATE_PARSER_ASSERT_SVH

// Same-cycle implication.
`define NRMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NRMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA RMC parser package
// Item types, parse phase codes, character constants and the header table.
// ----------------------------------------------------------------------------
package nrmc_pkg;

  localparam int unsigned BUF_BYTES_DEF = 128;
  localparam logic [31:0] ARRIVAL_LIMIT_RESET = 32'd800000;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_EOM  = 1'b1;

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_HEX1 = 3'd2;
  localparam logic [2:0] PH_HEX2 = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;
  localparam logic [2:0] PH_BAD  = 3'd5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [2:0] HDR_LEN    = 3'd6;
  localparam logic [4:0] COMMA_MAX  = 5'd31;
  localparam logic [4:0] COMMA_UTC  = 5'd1;
  localparam logic [4:0] COMMA_DATE = 5'd9;
  localparam logic [4:0] COMMA_UTC_END  = 5'd2;
  localparam logic [4:0] COMMA_DATE_END = 5'd10;
  localparam logic [7:0] DIGITS_MAX = 8'd6;
  localparam logic [7:0] FLEN_MAX   = 8'd255;

  typedef struct packed {
    logic        func;
    logic [7:0]  rx_byte;
    logic [31:0] arrival_time;
    logic [31:0] pps_elapsed;
  } in_item_t;

  typedef struct packed {
    logic        sentence_ok;
    logic        updated;
    logic [19:0] utc_hms;
    logic [19:0] utc_date;
    logic [31:0] utc_reference;
  } out_item_t;

  // "$GPRMC"
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Bit 4 set means the character is a valid hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] h;
    if (c >= 8'h30 && c <= 8'h39) begin
      h = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h = {1'b1, c[3:0] + 4'd9};
    end else begin
      h = 5'd0;
    end
    return h;
  endfunction

endpackage

>>> rtl/core/nmea_rmc_time_date_parser.sv
// ----------------------------------------------------------------------------
// NMEA RMC time/date parser, top level
// Parses RMC sentences byte by byte and keeps the last accepted UTC and date.
// ----------------------------------------------------------------------------
// Feed the bytes of one sentence as items with func = 0, then one item with
// func = 1 to close it. Only the closing item gives a result: sentence_ok
// (leading '$', '*' inside the buffer, two hex digits matching the XOR of
// the bytes between '$' and '*'), updated (a "$GPRMC" sentence with at least
// ten commas, a UTC field of six or more characters, a date field of exactly
// six, and arrival_time below arrival_limit), and the stored UTC, date and
// PPS reference after this sentence. Bytes past BUF_BYTES are dropped.
// Throughput is one item per clock unless a closing item is held: each item
// passes through the input register and is folded into the sentence state on
// the way out. A byte item never waits in the input register; a closing item
// waits there only while the result register still holds an untaken result,
// and in_ready stays low meanwhile. With the result register free, a closing
// item moves from the input register into the result register, which raises
// out_valid. Write cfg_wdata with cfg_we only while no sentence is in flight.
module nmea_rmc_time_date_parser
  import nrmc_pkg::*;
#(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic      s1_valid;
  in_item_t  s1_data;
  logic      s1_move;
  logic      out_free;
  logic      out_load;
  out_item_t res;

  // Advance a byte at once; hold a closing item until the result slot frees.
  assign s1_move  = s1_valid && ((s1_data.func == FUNC_BYTE) || out_free);
  assign out_load = s1_move && (s1_data.func == FUNC_EOM);

  nrmc_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s1_move  (s1_move),
    .s1_valid (s1_valid),
    .s1_data  (s1_data)
  );

  nrmc_parse #(
    .BUF_BYTES (BUF_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (s1_move),
    .item      (s1_data),
    .result    (res)
  );

  nrmc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`include "nmea_rmc_time_date_parser_assert.svh"

  // Only a closing item may stall in the input register.
  `NRMC_ASSERT_NOW(a_stall_eom, s1_valid && !s1_move, s1_data.func == FUNC_EOM, "byte item stalled")
  // An update implies a good checksum.
  `NRMC_ASSERT_NOW(a_upd_ok, out_valid && out_data.updated, out_data.sentence_ok, "update without ok")
  // A loaded update carries the PPS value of its closing item.
  `NRMC_ASSERT_NEXT(a_ref_cap, out_load && res.updated, out_data.utc_reference == $past(s1_data.pps_elapsed), "reference not captured")
  // Loading a result always raises out_valid.
  `NRMC_ASSERT_NEXT(a_load_valid, out_load, out_valid, "result lost")

endmodule

>>> rtl/core/nrmc_in_reg.sv
// ----------------------------------------------------------------------------
// NMEA RMC input register
// Holds one accepted item until the parse stage consumes it.
// ----------------------------------------------------------------------------
module nrmc_in_reg
  import nrmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     s1_move,
  output logic     s1_valid,
  output in_item_t s1_data
);

  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

endmodule

>>> rtl/core/nrmc_parse.sv
// ----------------------------------------------------------------------------
// NMEA RMC sentence parser
// Per-byte framing, checksum and field conversion; end-of-message decision.
// ----------------------------------------------------------------------------
module nrmc_parse
  import nrmc_pkg::*;
#(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        advance,
  input  in_item_t    item,
  output out_item_t   result
);

  localparam int unsigned POS_W = $clog2(BUF_BYTES + 1);
  localparam logic [POS_W-1:0] POS_END = POS_W'(BUF_BYTES);
  localparam logic [POS_W-1:0] POS_HDR = POS_W'(HDR_LEN);

  logic [31:0]      arrival_limit;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [2:0]       parse_phase, parse_phase_next;
  logic [7:0]       running_xor, running_xor_next;
  logic [2:0]       header_matched, header_matched_next;
  logic [4:0]       comma_count, comma_count_next;
  logic [7:0]       field_length, field_length_next;
  logic [7:0]       utc_field_length, utc_field_length_next;
  logic [7:0]       date_field_length, date_field_length_next;
  logic [19:0]      utc_accumulator, utc_accumulator_next;
  logic [19:0]      date_accumulator, date_accumulator_next;
  logic [7:0]       received_checksum, received_checksum_next;
  logic             run_live, run_live_next;
  logic [19:0]      stored_utc, stored_utc_next;
  logic [19:0]      stored_date, stored_date_next;
  logic [31:0]      stored_reference, stored_reference_next;

  logic [7:0]  c;
  logic [4:0]  hx;
  logic [4:0]  cc_inc;
  logic        is_digit;
  logic [19:0] dval;
  logic        ok;
  logic        upd;

  assign c        = item.rx_byte;
  assign hx       = hex_digit(c);
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign dval     = {16'd0, c[3:0]};
  assign cc_inc   = (comma_count < COMMA_MAX) ? comma_count + 5'd1 : comma_count;

  assign ok  = (parse_phase == PH_DONE);
  assign upd = ok && (header_matched == HDR_LEN) && (comma_count >= COMMA_DATE_END) &&
               (utc_field_length >= DIGITS_MAX) && (date_field_length == DIGITS_MAX) &&
               (item.arrival_time < arrival_limit);

  always_comb begin
    byte_position_next     = byte_position;
    parse_phase_next       = parse_phase;
    running_xor_next       = running_xor;
    header_matched_next    = header_matched;
    comma_count_next       = comma_count;
    field_length_next      = field_length;
    utc_field_length_next  = utc_field_length;
    date_field_length_next = date_field_length;
    utc_accumulator_next   = utc_accumulator;
    date_accumulator_next  = date_accumulator;
    received_checksum_next = received_checksum;
    run_live_next          = run_live;
    stored_utc_next        = stored_utc;
    stored_date_next       = stored_date;
    stored_reference_next  = stored_reference;

    if (item.func == FUNC_EOM) begin
      if (upd) begin
        stored_utc_next       = utc_accumulator;
        stored_date_next      = date_accumulator;
        stored_reference_next = item.pps_elapsed;
      end
      byte_position_next     = '0;
      parse_phase_next       = PH_WAIT;
      running_xor_next       = '0;
      header_matched_next    = '0;
      comma_count_next       = '0;
      field_length_next      = '0;
      utc_field_length_next  = '0;
      date_field_length_next = '0;
      utc_accumulator_next   = '0;
      date_accumulator_next  = '0;
      received_checksum_next = '0;
      run_live_next          = 1'b1;
    end else if (byte_position < POS_END) begin
      byte_position_next = byte_position + POS_W'(1);
      if ((byte_position < POS_HDR) && (c == hdr_char(byte_position[2:0])) &&
          (POS_W'(header_matched) == byte_position)) begin
        header_matched_next = header_matched + 3'd1;
      end
      unique case (parse_phase)
        PH_WAIT: begin
          parse_phase_next = (c == CH_DOLLAR) ? PH_BODY : PH_BAD;
        end
        PH_BODY: begin
          if (c == CH_STAR) begin
            parse_phase_next = PH_HEX1;
          end else begin
            running_xor_next = running_xor ^ c;
            if (c == CH_COMMA) begin
              comma_count_next = cc_inc;
              if (cc_inc == COMMA_UTC_END) utc_field_length_next = field_length;
              if (cc_inc == COMMA_DATE_END) date_field_length_next = field_length;
              field_length_next = '0;
              run_live_next     = 1'b1;
            end else begin
              if (((comma_count == COMMA_UTC) || (comma_count == COMMA_DATE)) &&
                  (field_length < DIGITS_MAX)) begin
                if (run_live && is_digit) begin
                  if (comma_count == COMMA_UTC) begin
                    utc_accumulator_next = (utc_accumulator << 3) +
                                           (utc_accumulator << 1) + dval;
                  end else begin
                    date_accumulator_next = (date_accumulator << 3) +
                                            (date_accumulator << 1) + dval;
                  end
                end else begin
                  run_live_next = 1'b0;
                end
              end
              if (field_length < FLEN_MAX) field_length_next = field_length + 8'd1;
            end
          end
        end
        PH_HEX1: begin
          if (!hx[4]) begin
            parse_phase_next = PH_BAD;
          end else begin
            received_checksum_next = {hx[3:0], 4'd0};
            parse_phase_next       = PH_HEX2;
          end
        end
        PH_HEX2: begin
          if (!hx[4]) begin
            parse_phase_next = PH_BAD;
          end else begin
            received_checksum_next = {received_checksum[7:4], hx[3:0]};
            parse_phase_next = ({received_checksum[7:4], hx[3:0]} == running_xor) ?
                               PH_DONE : PH_BAD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_limit <= ARRIVAL_LIMIT_RESET;
    end else if (cfg_we) begin
      arrival_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      parse_phase       <= PH_WAIT;
      running_xor       <= '0;
      header_matched    <= '0;
      comma_count       <= '0;
      field_length      <= '0;
      utc_field_length  <= '0;
      date_field_length <= '0;
      utc_accumulator   <= '0;
      date_accumulator  <= '0;
      received_checksum <= '0;
      run_live          <= 1'b1;
      stored_utc        <= '0;
      stored_date       <= '0;
      stored_reference  <= '0;
    end else if (advance) begin
      byte_position     <= byte_position_next;
      parse_phase       <= parse_phase_next;
      running_xor       <= running_xor_next;
      header_matched    <= header_matched_next;
      comma_count       <= comma_count_next;
      field_length      <= field_length_next;
      utc_field_length  <= utc_field_length_next;
      date_field_length <= date_field_length_next;
      utc_accumulator   <= utc_accumulator_next;
      date_accumulator  <= date_accumulator_next;
      received_checksum <= received_checksum_next;
      run_live          <= run_live_next;
      stored_utc        <= stored_utc_next;
      stored_date       <= stored_date_next;
      stored_reference  <= stored_reference_next;
    end
  end

  assign result.sentence_ok   = ok;
  assign result.updated       = upd;
  assign result.utc_hms       = stored_utc_next;
  assign result.utc_date      = stored_date_next;
  assign result.utc_reference = stored_reference_next;

endmodule

>>> rtl/core/nrmc_out_reg.sv
// ----------------------------------------------------------------------------
// NMEA RMC result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module nrmc_out_reg
  import nrmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t res,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

>>> dv/nmea_rmc_time_date_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA RMC time/date parser testbench
// Sends RMC sentences byte by byte: hand-built ones for framing, checksum,
// field and buffer rules, then random ones. An internal copy of the parser
// state predicts every result, and the checker compares each result field by
// field. Both handshakes idle at random, and the arrival limit is changed
// between phases.
// ----------------------------------------------------------------------------
module nmea_rmc_time_date_parser_tb;
  import nrmc_pkg::*;

  localparam int BUF_LEN = BUF_BYTES_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_PHASES = 4;
  localparam int LINES_PER_PHASE = 3;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  // Leading RMC tag; a sentence updates only if it opens with all six.
  localparam logic [7:0] RMC_TAG [6] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};
  // Characters just outside each hex digit range: / : @ G ` g
  localparam logic [7:0] NOT_HEX [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

  typedef enum {SUM_UPPER, SUM_LOWER, SUM_WRONG, SUM_BADHEX, SUM_NONE} sum_kind_t;
  typedef logic [7:0] octet_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  nmea_rmc_time_date_parser #(.BUF_BYTES(BUF_LEN)) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser prediction: per-sentence scan state plus the stored fix
  // --------------------------------------------------------------------------
  int unsigned sent_pos;
  logic [2:0]  stage;
  logic [7:0]  xor_acc;
  int          hdr_hits;
  logic [4:0]  commas;
  logic [7:0]  flen;
  logic [7:0]  utc_len;
  logic [7:0]  date_len;
  logic [19:0] utc_num;
  logic [19:0] date_num;
  logic [7:0]  rx_sum;
  bit          digits_live;
  logic [19:0] keep_utc;
  logic [19:0] keep_date;
  logic [31:0] keep_ref;
  logic [31:0] limit_reg;

  out_item_t   time_reports_q[$];  // results owed by the block, oldest first
  octet_q_t    line_q;             // sentence under construction

  bit          failed;
  bit          full_rate;          // no idling on either side
  int          burst_left;
  int          cycle_count;
  bit          rdy_hold;
  int          rdy_left;
  out_item_t   head;

  function automatic void start_sentence();
    sent_pos = 0;
    stage = PH_WAIT;
    xor_acc = '0;
    hdr_hits = 0;
    commas = '0;
    flen = '0;
    utc_len = '0;
    date_len = '0;
    utc_num = '0;
    date_num = '0;
    rx_sum = '0;
    digits_live = 1'b1;
  endfunction

  // Returns the nibble value, or -1 when the character is not a hex digit.
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic void scan_body(input logic [7:0] c);
    if (c == CH_STAR) begin
      stage = PH_HEX1;
      return;
    end
    xor_acc ^= c;
    if (c == CH_COMMA) begin
      if (commas != COMMA_MAX) commas++;
      if (commas == COMMA_UTC_END) utc_len = flen;
      if (commas == COMMA_DATE_END) date_len = flen;
      flen = '0;
      digits_live = 1'b1;
      return;
    end
    // Only the first six characters of the UTC and date fields matter; the
    // number ends at the first non-digit.
    if ((commas == COMMA_UTC || commas == COMMA_DATE) && flen < DIGITS_MAX) begin
      if (digits_live && c >= CH_ZERO && c <= CH_NINE) begin
        if (commas == COMMA_UTC) utc_num = utc_num * 10 + 20'(c - CH_ZERO);
        else date_num = date_num * 10 + 20'(c - CH_ZERO);
      end else begin
        digits_live = 1'b0;
      end
    end
    if (flen != FLEN_MAX) flen++;
  endfunction

  function automatic void absorb_byte(input logic [7:0] c);
    int unsigned p;
    int h;
    // Drop bytes past the end of the buffer.
    if (sent_pos >= BUF_LEN) return;
    p = sent_pos;
    sent_pos++;
    if (p < 6 && c == RMC_TAG[p] && hdr_hits == p) hdr_hits = p + 1;
    case (stage)
      PH_WAIT: stage = (c == CH_DOLLAR) ? PH_BODY : PH_BAD;
      PH_BODY: scan_body(c);
      PH_HEX1: begin
        h = nibble_of(c);
        if (h < 0) begin
          stage = PH_BAD;
        end else begin
          rx_sum = 8'(h << 4);
          stage = PH_HEX2;
        end
      end
      PH_HEX2: begin
        h = nibble_of(c);
        if (h < 0) begin
          stage = PH_BAD;
        end else begin
          rx_sum = rx_sum | 8'(h);
          stage = (rx_sum == xor_acc) ? PH_DONE : PH_BAD;
        end
      end
      default: ;  // hold: trailing bytes after the checksum change nothing
    endcase
  endfunction

  function automatic void close_sentence(input in_item_t it);
    out_item_t r;
    r.sentence_ok = (stage == PH_DONE);
    r.updated = r.sentence_ok && hdr_hits == HDR_LEN && commas >= COMMA_DATE_END &&
                utc_len >= DIGITS_MAX && date_len == DIGITS_MAX &&
                it.arrival_time < limit_reg;
    if (r.updated) begin
      keep_utc = utc_num;
      keep_date = date_num;
      keep_ref = it.pps_elapsed;
    end
    r.utc_hms = keep_utc;
    r.utc_date = keep_date;
    r.utc_reference = keep_ref;
    time_reports_q.push_back(r);
    start_sentence();
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (time_reports_q.size() == 0) begin
        $error("result with no closed sentence pending");
        failed = 1'b1;
      end else begin
        head = time_reports_q.pop_front();
        check_field("sentence_ok", head.sentence_ok, out_data.sentence_ok);
        check_field("updated", head.updated, out_data.updated);
        check_field("utc_hms", head.utc_hms, out_data.utc_hms);
        check_field("utc_date", head.utc_date, out_data.utc_date);
        check_field("utc_reference", head.utc_reference, out_data.utc_reference);
      end
    end
  end

  // Receiver: alternate ready and stall runs of random length.
  always @(posedge clk) begin
    if (full_rate) begin
      out_ready <= 1'b1;
    end else begin
      if (rdy_left == 0) begin
        rdy_hold = !rdy_hold;
        rdy_left = rdy_hold ? $urandom_range(1, 16) : $urandom_range(1, 5);
      end else begin
        rdy_left--;
      end
      out_ready <= rdy_hold;
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // Call at a rising edge; returns at the edge where the item is accepted.
  // Valid stays high between back-to-back items, so it is only lowered at the
  // start of a gap.
  task automatic send_item(input in_item_t it);
    int gap;
    if (!full_rate && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (it.func == FUNC_EOM) close_sentence(it);
    else absorb_byte(it.rx_byte);
  endtask

  // Send the bytes in line_q, then the end-of-message item.
  task automatic ship_line(input logic [31:0] arrival, input logic [31:0] pps);
    in_item_t it;
    foreach (line_q[i]) begin
      it.func = FUNC_BYTE;
      it.rx_byte = line_q[i];
      it.arrival_time = $urandom;
      it.pps_elapsed = $urandom;
      send_item(it);
    end
    it.func = FUNC_EOM;
    it.rx_byte = 8'($urandom);
    it.arrival_time = arrival;
    it.pps_elapsed = pps;
    send_item(it);
    line_q.delete();
  endtask

  // Lower valid, wait for every owed result, then let the pipeline settle.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (time_reports_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_arrival_limit(input logic [31:0] v);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = v;
  endtask

  // --------------------------------------------------------------------------
  // Sentence building
  // --------------------------------------------------------------------------
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  // Standard RMC layout: the date sits between the ninth and tenth comma.
  function automatic void add_rmc(input string talker, input string utc,
                                  input string date, input int tail);
    add_text({"$", talker, ",", utc, ",A,4807.038,N,01131.000,E,022.4,084.4,", date});
    for (int i = 0; i < tail; i++) add_text((i == 0) ? ",003.1" : ",W");
  endfunction

  function automatic void add_sum(input sum_kind_t k);
    logic [7:0] x;
    logic [7:0] bad;
    x = '0;
    for (int i = 1; i < line_q.size(); i++) x ^= line_q[i];
    bad = NOT_HEX[$urandom_range(0, 5)];
    case (k)
      SUM_UPPER: add_text($sformatf("*%02X", x));
      SUM_LOWER: add_text($sformatf("*%02x", x));
      SUM_WRONG: add_text($sformatf("*%02X", x ^ 8'($urandom_range(1, 255))));
      SUM_BADHEX: begin
        if ($urandom_range(0, 1) == 0) add_text($sformatf("*%c%X", bad, x[3:0]));
        else add_text($sformatf("*%X%c", x[7:4], bad));
      end
      default: ;  // leave the star off
    endcase
  endfunction

  function automatic logic [7:0] rand_printable();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126)); while (c == CH_COMMA || c == CH_STAR);
    return c;
  endfunction

  function automatic logic [7:0] rand_nondigit();
    logic [7:0] c;
    do c = rand_printable(); while (c >= CH_ZERO && c <= CH_NINE);
    return c;
  endfunction

  function automatic string rand_field(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = $sformatf("%s%c", s, rand_printable());
    return s;
  endfunction

  function automatic string rand_digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
    return s;
  endfunction

  // Mostly a plain hhmmss, sometimes with hundredths, short or broken by a non-digit.
  function automatic string rand_utc();
    string s;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      s = rand_digits(6);
      if ($urandom_range(0, 1) == 1) s = {s, ".", rand_digits(2)};
    end else if (r < 8) begin
      s = rand_digits($urandom_range(0, 5));
    end else begin
      s = rand_digits($urandom_range(6, 9));
      s.putc($urandom_range(0, s.len() - 1), rand_nondigit());
    end
    return s;
  endfunction

  function automatic string rand_date();
    string s;
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) begin
      s = rand_digits(6);
    end else if (r == 8) begin
      s = rand_digits($urandom_range(0, 1) ? 5 : $urandom_range(0, 8));
    end else begin
      s = rand_digits(6);
      s.putc($urandom_range(0, 5), rand_nondigit());
    end
    return s;
  endfunction

  function automatic logic [31:0] pick_arrival();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return (limit_reg == 0) ? 32'd0 : $urandom_range(0, limit_reg - 1);
    if (r < 15) return $urandom;
    if (r < 17) return limit_reg - 1;
    if (r < 19) return limit_reg;
    return 32'hFFFF_FFFF;
  endfunction

  // Mostly well-formed RMC sentences with random content; the rest is noise,
  // empty, overlong, or broken after the checksum was computed.
  task automatic build_random_line();
    int kind;
    int nmid;
    int tail;
    int r;
    string talker;
    sum_kind_t k;
    kind = $urandom_range(0, 99);
    if (kind < 5) return;  // empty sentence
    if (kind < 15) begin
      repeat ($urandom_range(1, 40)) line_q.push_back(8'($urandom));
      if ($urandom_range(0, 1) == 1) line_q[0] = CH_DOLLAR;
      return;
    end
    if ($urandom_range(0, 9) != 0) begin
      talker = "GPRMC";
    end else begin
      case ($urandom_range(0, 3))
        0: talker = "GNRMC";
        1: talker = "GPGGA";
        2: talker = "GPRMc";
        default: talker = "GPRMD";
      endcase
    end
    add_text({"$", talker, ",", rand_utc()});
    nmid = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : 7;
    repeat (nmid) add_text({",", rand_field($urandom_range(0, 10))});
    add_text({",", rand_date()});
    tail = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    repeat (tail) add_text({",", rand_field($urandom_range(0, 6))});
    if (kind < 20) add_text({",", rand_field($urandom_range(60, 140))});
    r = $urandom_range(0, 19);
    k = (r < 7) ? SUM_UPPER : (r < 14) ? SUM_LOWER : (r < 17) ? SUM_WRONG :
        (r < 19) ? SUM_BADHEX : SUM_NONE;
    add_sum(k);
    if (kind >= 20 && kind < 30) begin
      if ($urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, line_q.size() - 1);
        line_q[r] = line_q[r] ^ 8'(1 << $urandom_range(0, 7));
      end else begin
        repeat ($urandom_range(1, line_q.size() - 1)) void'(line_q.pop_back());
      end
    end
    if ($urandom_range(0, 6) == 0) begin
      if ($urandom_range(0, 1) == 0) add_text("\r\n");
      else repeat ($urandom_range(1, 5)) line_q.push_back(8'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_empty_sentence();
    ship_line(32'd0, 32'h1234_5678);     // end of message with no bytes
    add_text("$");
    ship_line(32'd0, 32'h1234_5678);     // lone start character
  endtask

  task automatic test_checksum_forms();
    add_rmc("GPRMC", "235959.99", "311299", 2);
    add_sum(SUM_UPPER);
    ship_line(32'd0, 32'hFFFF_FFFF);
    add_rmc("GPRMC", "123519", "230394", 2);
    add_sum(SUM_LOWER);
    ship_line(limit_reg - 1, 32'd0);
    add_rmc("GPRMC", "010203", "040506", 1);
    add_sum(SUM_WRONG);
    ship_line(32'd5, 32'hA5A5_A5A5);
    add_rmc("GPRMC", "010203", "040506", 1);
    add_sum(SUM_BADHEX);
    ship_line(32'd5, 32'h5A5A_5A5A);
    add_rmc("GPRMC", "010203", "040506", 1);
    add_sum(SUM_NONE);
    ship_line(32'd5, 32'h0F0F_0F0F);
    // Line ending after the checksum is ignored.
    add_rmc("GPRMC", "111111", "121212", 2);
    add_sum(SUM_UPPER);
    add_text("\r\n");
    ship_line(32'd7, 32'h0000_0001);
    // Missing leading dollar.
    add_rmc("GPRMC", "222222", "131313", 2);
    void'(line_q.pop_front());
    add_sum(SUM_UPPER);
    ship_line(32'd7, 32'h0000_0002);
  endtask

  task automatic test_field_rules();
    add_rmc("GPGGA", "123519", "230394", 2);   // other sentence type
    add_sum(SUM_UPPER);
    ship_line(32'd1, 32'd11);
    add_rmc("GPRMC", "123519", "230394", 0);   // only nine commas
    add_sum(SUM_UPPER);
    ship_line(32'd1, 32'd12);
    add_rmc("GPRMC", "12351", "230394", 2);    // UTC field too short
    add_sum(SUM_UPPER);
    ship_line(32'd1, 32'd13);
    add_rmc("GPRMC", "", "230394", 2);         // empty UTC field
    add_sum(SUM_LOWER);
    ship_line(32'd1, 32'd14);
    add_rmc("GPRMC", "12a519", "230394", 2);   // number stops at the letter
    add_sum(SUM_UPPER);
    ship_line(32'd1, 32'd15);
    add_rmc("GPRMC", "123519", "23039", 2);    // date too short
    add_sum(SUM_UPPER);
    ship_line(32'd1, 32'd16);
    add_rmc("GPRMC", "123519", "2303944", 2);  // date too long
    add_sum(SUM_UPPER);
    ship_line(32'd1, 32'd17);
    add_rmc("GPRMC", "654321", "ab0394", 2);   // date with no leading digit
    add_sum(SUM_UPPER);
    ship_line(32'd1, 32'd18);
    add_rmc("GPRMC", "000000", "000000", 30);  // comma count saturates
    add_sum(SUM_UPPER);
    ship_line(32'd1, 32'd0);
    // Extreme byte values inside a field.
    add_rmc("GPRMC", "999999", "999999", 2);
    add_text(",");
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    line_q.push_back(8'h80);
    line_q.push_back(8'h7F);
    add_sum(SUM_UPPER);
    ship_line(32'd1, 32'hDEAD_BEEF);
  endtask

  task automatic test_buffer_edge();
    // Last checksum digit at the final buffer position: valid.
    add_rmc("GPRMC", "120000", "010100", 2);
    while (line_q.size() < BUF_LEN - 3) line_q.push_back("X");
    add_sum(SUM_UPPER);
    ship_line(32'd3, 32'h0000_1000);
    // One byte longer: the last digit is dropped.
    add_rmc("GPRMC", "130000", "020200", 2);
    while (line_q.size() < BUF_LEN - 2) line_q.push_back("X");
    add_sum(SUM_UPPER);
    ship_line(32'd3, 32'h0000_2000);
    add_rmc("GPRMC", "140000", "030300", 2);
    while (line_q.size() < 200) line_q.push_back("Y");
    add_sum(SUM_LOWER);
    ship_line(32'd3, 32'h0000_3000);
  endtask

  task automatic test_arrival_limit();
    write_arrival_limit(32'd0);           // nothing can update
    add_rmc("GPRMC", "101010", "101010", 2);
    add_sum(SUM_UPPER);
    ship_line(32'd0, 32'h1111_1111);
    write_arrival_limit(32'hFFFF_FFFF);
    add_rmc("GPRMC", "202020", "202020", 2);
    add_sum(SUM_UPPER);
    ship_line(32'hFFFF_FFFE, 32'h2222_2222);
    add_rmc("GPRMC", "212121", "212121", 2);
    add_sum(SUM_UPPER);
    ship_line(32'hFFFF_FFFF, 32'h3333_3333);
    write_arrival_limit(32'd1);
    add_rmc("GPRMC", "030303", "030303", 2);
    add_sum(SUM_UPPER);
    ship_line(32'd0, 32'h4444_4444);
    add_rmc("GPRMC", "040404", "040404", 2);
    add_sum(SUM_UPPER);
    ship_line(32'd1, 32'h5555_5555);
  endtask

  // One phase per limit kind; the third phase runs both sides at full rate.
  task automatic test_random_sentences();
    logic [31:0] lim;
    for (int phase_no = 0; phase_no < RAND_PHASES; phase_no++) begin
      case (phase_no % 4)
        0: lim = ARRIVAL_LIMIT_RESET;
        1: lim = 32'hFFFF_FFFF;
        2: lim = $urandom;
        default: lim = $urandom_range(0, 2000000);
      endcase
      write_arrival_limit(lim);
      full_rate = (phase_no % 3 == 2);
      repeat (LINES_PER_PHASE) begin
        build_random_line();
        ship_line(pick_arrival(), $urandom);
      end
    end
    full_rate = 1'b0;
  endtask

  initial begin
    start_sentence();
    keep_utc = '0;
    keep_date = '0;
    keep_ref = '0;
    limit_reg = ARRIVAL_LIMIT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_sentence();
    test_checksum_forms();
    test_field_rules();
    test_buffer_edge();
    test_arrival_limit();
    test_random_sentences();

    wait_for_results();
    if (failed) begin
      $display("simulation failed");
    end else begin
      $display("simulation ok");
    end
    $finish;
  end

endmodule
